>>> rtl/core/frontier_cell_detection_defines.svh
// Assertion macros for the frontier cell detector.
// Used by the top level only; no other dependencies.
`ifndef FRONTIER_CELL_DETECTION_DEFINES_SVH
`define FRONTIER_CELL_DETECTION_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define FCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frontier cell detection: same-cycle check failed");

// Check a condition in the cycle after its trigger
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frontier cell detection: next-cycle check failed");

`endif

>>> rtl/core/fcd_pkg.sv
// Shared types and constants for the frontier cell detector.
// No dependencies; imported by the top level.
package fcd_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int CELL_IDX_W  = 20;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 4'd1;

    // Input commands
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Cell value codes
    localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;
    localparam logic signed [7:0] OCC_FREE    = 8'sd0;

    // A cell is strongly unknown with more than this many unknown neighbors
    localparam logic [3:0] STRONG_MIN_EXCL = 4'd2;

    // Result queue
    localparam int          FIFO_PTR_W = 2;
    localparam logic [2:0]  FIFO_DEPTH = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic signed [7:0] occupancy;
    } t_in_word;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_index;
        logic                  is_frontier;
        logic                  last_cell;
    } t_out_word;

    // One column of a 3x3 window, top row oldest
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_col3;

    // Unknown line store entry: marks of the two rows above the newest cell
    typedef struct packed {
        logic unk_top;
        logic unk_mid;
        logic free_mid;
    } t_line_a;

    // Strong line store entry: marks of the two rows above the settled cell
    typedef struct packed {
        logic str_top;
        logic str_mid;
        logic free_mid;
    } t_line_b;

endpackage

>>> rtl/core/frontier_cell_detection.sv
// Frontier cell detector, top level: line stores, 3x3 windows, result queue.
// Depends on fcd_pkg and frontier_cell_detection_defines.svh.
// Reporting: a cell is reported 2*grid_width+2 advances after it enters, then passes
//   through the line store A read, line store B read and result queue registers.
// Throughput: one word per cycle while o_in_stall is low, set by the read-modify-write
//   path of each line store; input stalls on queue fill and after a configuration write.
// Reset: clears counters, pipeline and queue, sets width and height to maximum;
//   line stores are not cleared, stale entries are masked by the row bounds.
`include "frontier_cell_detection_defines.svh"

module frontier_cell_detection
    import fcd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_word              o_out_word,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int WDW  = $clog2(MAX_WIDTH + 1);
    localparam int HDW  = $clog2(MAX_HEIGHT + 1);
    localparam int ROWW = $clog2(MAX_HEIGHT) + 3;
    localparam int VW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

    localparam logic signed [ROWW-1:0] ROW_ZERO = '0;
    localparam logic signed [ROWW-1:0] ROW_ONE  = ROWW'(1);
    localparam logic signed [ROWW-1:0] ROW_TWO  = ROWW'(2);

    function automatic logic [3:0] count_set(input logic [7:0] bits);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, bits[i]};
        end
        return n;
    endfunction

    // ---------------- configuration ----------------
    logic [WDW-1:0] r_width;
    logic [HDW-1:0] r_height;
    logic [VW-1:0]  r_total;
    logic [VW-1:0]  r_total_m1;
    logic [VW-1:0]  r_lag;
    logic [1:0]     r_cfg_hold;
    logic           cfg_wr;
    logic [WDW-1:0] cfg_w_val;
    logic [HDW-1:0] cfg_h_val;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready &&
                         (i_cfg_index == CFG_GRID_WIDTH || i_cfg_index == CFG_GRID_HEIGHT);

    // Clamp the written dimension into its legal range
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w_val = WDW'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            cfg_w_val = WDW'(MAX_WIDTH);
        end else begin
            cfg_w_val = WDW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            cfg_h_val = HDW'(1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            cfg_h_val = HDW'(MAX_HEIGHT);
        end else begin
            cfg_h_val = HDW'(i_cfg_data);
        end
    end

    // Hold registers and derived frame sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WDW'(MAX_WIDTH);
            r_height   <= HDW'(MAX_HEIGHT);
            r_total    <= VW'(MAX_WIDTH * MAX_HEIGHT);
            r_total_m1 <= VW'(MAX_WIDTH * MAX_HEIGHT - 1);
            r_lag      <= VW'(2 * MAX_WIDTH + 2);
            r_cfg_hold <= 2'b00;
        end else begin
            if (cfg_wr && i_cfg_index == CFG_GRID_WIDTH) begin
                r_width <= cfg_w_val;
            end
            if (cfg_wr && i_cfg_index == CFG_GRID_HEIGHT) begin
                r_height <= cfg_h_val;
            end
            r_total    <= VW'(r_width) * VW'(r_height);
            r_total_m1 <= r_total - VW'(1);
            r_lag      <= VW'({r_width, 1'b0}) + VW'(2);
            r_cfg_hold <= cfg_wr ? 2'b11 : {1'b0, r_cfg_hold[1]};
        end
    end

    // ---------------- stage 0: accept and position ----------------
    logic [VW-1:0]          r_v;
    logic [COLW-1:0]        r_col;
    logic signed [ROWW-1:0] r_row;
    logic [COLW-1:0]        w_m1;
    logic signed [ROWW-1:0] h_s;
    logic                   in_acc;
    logic                   ge_total;
    logic                   adv;
    logic                   s0_unk;
    logic                   s0_free;
    logic [VW-1:0]          s0_q;
    logic                   s0_emit;
    logic                   s0_last;
    logic [COLW-1:0]        s0_coln;
    logic signed [ROWW-1:0] s0_rown;
    logic [2:0]             in_flight;
    logic [2:0]             r_fifo_cnt;
    logic                   r_s1_valid;
    logic                   r_s2_valid;

    assign w_m1 = COLW'(r_width - WDW'(1));
    assign h_s  = $signed(ROWW'(r_height));

    // Stall when the queue could not absorb every word still in the pipeline
    assign in_flight  = r_fifo_cnt + {2'b00, r_s1_valid} + {2'b00, r_s2_valid};
    assign o_in_stall = (r_cfg_hold != 2'b00) || (in_flight > 3'd3);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        ge_total = (r_v >= r_total);
        adv      = in_acc && (ge_total || i_in_word.cmd == CMD_CELL);
        s0_unk   = !ge_total && (i_in_word.occupancy == OCC_UNKNOWN);
        s0_free  = !ge_total && (i_in_word.occupancy == OCC_FREE);
        s0_q     = r_v - r_lag;
        s0_emit  = (r_v >= r_lag) && (s0_q < r_total);
        s0_last  = s0_emit && (s0_q == r_total_m1);
        // settled cell sits one row and one column behind the newest cell
        s0_coln  = (r_col == '0) ? w_m1 : r_col - COLW'(1);
        s0_rown  = r_row - ((r_col == '0) ? ROW_TWO : ROW_ONE);
    end

    // Advance the raster position, restart after the last report or a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_col <= '0;
            r_row <= ROW_ZERO;
        end else if (cfg_wr) begin
            r_v   <= '0;
            r_col <= '0;
            r_row <= ROW_ZERO;
        end else if (adv) begin
            if (s0_last) begin
                r_v   <= '0;
                r_col <= '0;
                r_row <= ROW_ZERO;
            end else begin
                r_v <= r_v + VW'(1);
                if (r_col == w_m1) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_ONE;
                end else begin
                    r_col <= r_col + COLW'(1);
                end
            end
        end
    end

    // ---------------- stage 1: unknown window, strong mark ----------------
    logic [COLW-1:0]        r_s1_col;
    logic [COLW-1:0]        r_s1_coln;
    logic signed [ROWW-1:0] r_s1_rown;
    logic                   r_s1_unk;
    logic                   r_s1_free;
    logic                   r_s1_emit;
    logic                   r_s1_last;
    logic [VW-1:0]          r_s1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col  <= r_col;
            r_s1_coln <= s0_coln;
            r_s1_rown <= s0_rown;
            r_s1_unk  <= s0_unk;
            r_s1_free <= s0_free;
            r_s1_emit <= s0_emit;
            r_s1_last <= s0_last;
            r_s1_q    <= s0_q;
        end
    end

    // Line store A: read at accept, write back in the next cycle
    t_line_a r_mem_a [MAX_WIDTH];
    t_line_a r_a_rd;
    t_line_a r_a_fwd_data;
    logic    r_a_fwd;
    t_line_a a_data;
    t_line_a a_wr;

    assign a_data = r_a_fwd ? r_a_fwd_data : r_a_rd;
    assign a_wr   = '{unk_top: a_data.unk_mid, unk_mid: r_s1_unk, free_mid: r_s1_free};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_rd <= r_mem_a[r_col];
        end
        if (r_s1_valid) begin
            r_mem_a[r_s1_col] <= a_wr;
        end
        r_a_fwd_data <= a_wr;
    end

    // Forward the write back when the next read hits the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_fwd <= 1'b0;
        end else begin
            r_a_fwd <= adv && r_s1_valid && (r_s1_col == r_col);
        end
    end

    t_col3 r_u1;
    t_col3 r_u2;
    logic  r_f1;
    t_col3 u_cur;
    logic  u_top_ok;
    logic  u_bot_ok;
    logic  u_left_ok;
    logic  u_right_ok;
    logic  n_in_frame;
    logic  [7:0] u_nb;
    logic  s1_strong;

    always_comb begin
        u_cur      = '{top: a_data.unk_top, mid: a_data.unk_mid, bot: r_s1_unk};
        u_top_ok   = (r_s1_rown >= ROW_ONE);
        u_bot_ok   = ((r_s1_rown + ROW_ONE) < h_s);
        u_left_ok  = (r_s1_coln != '0);
        u_right_ok = (r_s1_coln != w_m1);
        n_in_frame = (r_s1_rown >= ROW_ZERO) && (r_s1_rown < h_s);
        u_nb = {r_u2.top & u_top_ok & u_left_ok,
                r_u2.mid & u_left_ok,
                r_u2.bot & u_bot_ok & u_left_ok,
                r_u1.top & u_top_ok,
                r_u1.bot & u_bot_ok,
                u_cur.top & u_top_ok & u_right_ok,
                u_cur.mid & u_right_ok,
                u_cur.bot & u_bot_ok & u_right_ok};
        s1_strong = n_in_frame && r_u1.mid && (count_set(u_nb) > STRONG_MIN_EXCL);
    end

    // Shift the unknown window by one column per advance
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_u2 <= r_u1;
            r_u1 <= u_cur;
            r_f1 <= a_data.free_mid;
        end
    end

    // ---------------- stage 2: strong window, frontier flag ----------------
    logic [COLW-1:0]        r_s2_coln;
    logic signed [ROWW-1:0] r_s2_rown;
    logic                   r_s2_strong;
    logic                   r_s2_free;
    logic                   r_s2_emit;
    logic                   r_s2_last;
    logic [VW-1:0]          r_s2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_coln   <= r_s1_coln;
            r_s2_rown   <= r_s1_rown;
            r_s2_strong <= s1_strong;
            r_s2_free   <= r_f1;
            r_s2_emit   <= r_s1_emit;
            r_s2_last   <= r_s1_last;
            r_s2_q      <= r_s1_q;
        end
    end

    // Line store B: read in stage 1, write back in stage 2
    t_line_b r_mem_b [MAX_WIDTH];
    t_line_b r_b_rd;
    t_line_b r_b_fwd_data;
    logic    r_b_fwd;
    t_line_b b_data;
    t_line_b b_wr;

    assign b_data = r_b_fwd ? r_b_fwd_data : r_b_rd;
    assign b_wr   = '{str_top: b_data.str_mid, str_mid: r_s2_strong, free_mid: r_s2_free};

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_b_rd <= r_mem_b[r_s1_coln];
        end
        if (r_s2_valid) begin
            r_mem_b[r_s2_coln] <= b_wr;
        end
        r_b_fwd_data <= b_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_fwd <= 1'b0;
        end else begin
            r_b_fwd <= r_s1_valid && r_s2_valid && (r_s2_coln == r_s1_coln);
        end
    end

    t_col3                  r_t1;
    t_col3                  r_t2;
    logic                   r_g1;
    t_col3                  t_cur;
    logic [COLW-1:0]        q_col;
    logic signed [ROWW-1:0] q_row;
    logic                   t_top_ok;
    logic                   t_bot_ok;
    logic                   t_left_ok;
    logic                   t_right_ok;
    logic [7:0]             t_nb;
    logic                   s2_front;

    always_comb begin
        t_cur      = '{top: b_data.str_top, mid: b_data.str_mid, bot: r_s2_strong};
        q_col      = (r_s2_coln == '0) ? w_m1 : r_s2_coln - COLW'(1);
        q_row      = r_s2_rown - ((r_s2_coln == '0) ? ROW_TWO : ROW_ONE);
        t_top_ok   = (q_row >= ROW_ONE);
        t_bot_ok   = ((q_row + ROW_ONE) < h_s);
        t_left_ok  = (q_col != '0);
        t_right_ok = (q_col != w_m1);
        t_nb = {r_t2.top & t_top_ok & t_left_ok,
                r_t2.mid & t_left_ok,
                r_t2.bot & t_bot_ok & t_left_ok,
                r_t1.top & t_top_ok,
                r_t1.bot & t_bot_ok,
                t_cur.top & t_top_ok & t_right_ok,
                t_cur.mid & t_right_ok,
                t_cur.bot & t_bot_ok & t_right_ok};
        s2_front = r_g1 && (t_nb != 8'h00);
    end

    // Shift the strong window by one column per advance
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_t2 <= r_t1;
            r_t1 <= t_cur;
            r_g1 <= b_data.free_mid;
        end
    end

    // ---------------- result queue ----------------
    t_out_word              r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic                   push;
    logic                   pop;
    logic [VW+CELL_IDX_W-1:0] q_ext;
    t_out_word              push_word;

    assign q_ext     = {{CELL_IDX_W{1'b0}}, r_s2_q};
    assign push_word = '{cell_index: q_ext[CELL_IDX_W-1:0],
                         is_frontier: s2_front,
                         last_cell: r_s2_last};
    assign push        = r_s2_valid && r_s2_emit;
    assign o_out_valid = (r_fifo_cnt != 3'd0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_word  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

    // Track queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + {2'b00, push} - {2'b00, pop};
        end
    end

    // ---------------- assertions ----------------
    `FCD_ASSERT_NOW(a_fifo_bound, i_clk, i_rst_n, push && !pop, r_fifo_cnt < FIFO_DEPTH)
    `FCD_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, adv && s0_last && !cfg_wr, r_v == '0)
    `FCD_ASSERT_NOW(a_cfg_hold_stalls, i_clk, i_rst_n, r_cfg_hold != 2'b00, o_in_stall)

endmodule

>>> tb/sv/frontier_cell_detection_tb.sv
`timescale 1ns / 100ps
// Testbench for frontier_cell_detection: directed and random grid frames with random idling.
// Each reported cell is checked against a frontier predictor kept in a small class.
// Depends on fcd_pkg and the frontier_cell_detection top level.
module frontier_cell_detection_tb;
    import fcd_pkg::*;

    localparam int     MAX_W         = 1024;
    localparam int     MAX_H         = 1024;
    localparam int     RING          = 2 * MAX_W + 4;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     RANDOM_ITEMS  = 900;
    localparam longint CYCLE_LIMIT   = 1000000;

    // Register indexes past the end of the list; writes to them are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = CFG_GRID_HEIGHT + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

    // Frontier predictor: grid geometry, mark rings and the reports still due
    class frontier_ledger;
        int unsigned width;
        int unsigned height;
        int unsigned advance;
        bit          unk_ring    [RING];
        bit          strong_ring [RING];
        bit          free_ring   [RING];
        t_out_word   due_reports [$];
        int          mismatches;
        int          reports_seen;
        int          frontier_hits;
        int          cells_taken;
        int          frames_done;
        int          flushes_dropped;

        function new();
            width  = MAX_W;
            height = MAX_H;
            restart();
        endfunction

        function void restart();
            advance = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v < 1) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_GRID_WIDTH) begin
                width = clamp_dim(data, MAX_W);
                restart();
            end else if (idx == CFG_GRID_HEIGHT) begin
                height = clamp_dim(data, MAX_H);
                restart();
            end
        endfunction

        // Count in-bounds neighbors of (r,c) marked in the unknown or strong ring
        function int unsigned count_marks(bit from_strong, int unsigned r, int unsigned c);
            int unsigned n;
            int          dr;
            int          dc;
            int          rr;
            int          cc;
            int          k;
            n = 0;
            for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                    rr = int'(r) + dr;
                    cc = int'(c) + dc;
                    if (dr == 0 && dc == 0) continue;
                    if (rr < 0 || cc < 0) continue;
                    if (rr >= int'(height) || cc >= int'(width)) continue;
                    k = (rr * int'(width) + cc) % RING;
                    if (from_strong ? strong_ring[k] : unk_ring[k]) n++;
                end
            end
            return n;
        endfunction

        // Advance the pipeline by one accepted word; returns 1 if it was an advance
        function bit take_word(t_in_word w);
            int unsigned total;
            int unsigned lag;
            int unsigned v;
            int unsigned n;
            int unsigned q;
            int unsigned k;
            t_out_word   rep;
            total = width * height;
            lag   = 2 * width + 2;
            v     = advance;
            if (v < total) begin
                // drop flushes until the frame is complete
                if (w.cmd == CMD_FLUSH) begin
                    flushes_dropped++;
                    return 1'b0;
                end
                k = v % RING;
                unk_ring[k]  = (w.occupancy == OCC_UNKNOWN);
                free_ring[k] = (w.occupancy == OCC_FREE);
                cells_taken++;
            end
            // settle the strong mark one row and one cell back
            if (v >= width + 1 && v - (width + 1) < total) begin
                n = v - (width + 1);
                k = n % RING;
                strong_ring[k] = unk_ring[k] &&
                                 (count_marks(1'b0, n / width, n % width) > STRONG_MIN_EXCL);
            end
            advance = v + 1;
            // report the cell two rows and two cells back
            if (v >= lag && v - lag < total) begin
                q = v - lag;
                rep.cell_index  = CELL_IDX_W'(q);
                rep.is_frontier = free_ring[q % RING] &&
                                  (count_marks(1'b1, q / width, q % width) > 0);
                rep.last_cell   = (q == total - 1);
                due_reports.push_back(rep);
                if (rep.last_cell) begin
                    frames_done++;
                    restart();
                end
            end
            return 1'b1;
        endfunction

        function void match_report(t_out_word got);
            t_out_word want;
            if (due_reports.size() == 0) begin
                mismatches++;
                $display("%0t: report with none due: expected none, got index %0d frontier %0b last %0b",
                         $time, got.cell_index, got.is_frontier, got.last_cell);
                return;
            end
            want = due_reports.pop_front();
            reports_seen++;
            if (want.is_frontier) frontier_hits++;
            if (got.cell_index !== want.cell_index) begin
                mismatches++;
                $display("%0t: cell_index mismatch: expected %0d, got %0d",
                         $time, want.cell_index, got.cell_index);
            end
            if (got.is_frontier !== want.is_frontier) begin
                mismatches++;
                $display("%0t: is_frontier mismatch at cell %0d: expected %0b, got %0b",
                         $time, want.cell_index, want.is_frontier, got.is_frontier);
            end
            if (got.last_cell !== want.last_cell) begin
                mismatches++;
                $display("%0t: last_cell mismatch at cell %0d: expected %0b, got %0b",
                         $time, want.cell_index, want.last_cell, got.last_cell);
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_word               i_in_word   = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_word              o_out_word;
    logic                   o_cfg_ready;

    frontier_ledger ledger = new();
    bit             steady = 1'b0;
    bit             tally  = 1'b0;
    int unsigned    counted = 0;
    int             cfg_writes = 0;
    longint         cycles = 0;

    frontier_cell_detection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still due",
                     cycles, ledger.due_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side at random, except in steady stretches
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 27);
    end

    // Sample results mid-cycle; stall and word hold through the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) ledger.match_report(o_out_word);
    end

    function automatic logic [7:0] pick_occupancy();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) return OCC_UNKNOWN;
        if (roll < 80) return OCC_FREE;
        return 8'($urandom);
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(logic cmd, logic [7:0] occ);
        t_in_word w;
        bit       taken;
        w.cmd       = cmd;
        w.occupancy = occ;
        while (!steady && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (ledger.take_word(w) && tally) counted++;
    endtask

    // Hold off input until every due report has come, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (ledger.due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit taken;
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        ledger.set_register(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stream one frame of random cells with stray flushes and a possible pause, then push the tail out unless aborted
    task automatic run_frame(bit force_pause, output bit aborted);
        int unsigned total;
        int unsigned pause_at;
        int unsigned abort_at;
        int unsigned i;
        total    = ledger.width * ledger.height;
        aborted  = 1'b0;
        pause_at = force_pause ? total / 2 :
                   ($urandom_range(5) == 0) ? $urandom_range(total - 1) : total;
        abort_at = (tally && total > 1 && $urandom_range(11) == 0) ?
                   $urandom_range(total - 1, 1) : total;
        for (i = 0; i < total; i++) begin
            if (i == abort_at) begin
                aborted = 1'b1;
                drain_results();
                return;
            end
            if (i == pause_at) drain_results();
            if ($urandom_range(15) == 0) send_word(CMD_FLUSH, 8'($urandom));
            send_word(CMD_CELL, pick_occupancy());
        end
        // after the last cell both flushes and cells only advance the pipeline
        while (ledger.advance != 0) send_word(1'($urandom_range(1)), 8'($urandom));
    endtask

    initial begin
        logic [7:0]  grid3 [9];
        bit          aborted;
        bit          force_cfg;
        int unsigned phase;
        int unsigned wr;
        int unsigned hr;
        int unsigned sel;
        aborted = 1'b0;
        phase   = 0;
        grid3   = '{OCC_UNKNOWN, OCC_UNKNOWN, OCC_UNKNOWN,
                    OCC_UNKNOWN, OCC_FREE,    8'h7F,
                    8'h80,       OCC_UNKNOWN, OCC_FREE};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Partial frame at the reset size; the flush comes early and is dropped
        send_word(CMD_CELL, OCC_UNKNOWN);
        send_word(CMD_CELL, OCC_FREE);
        send_word(CMD_CELL, 8'h80);
        send_word(CMD_FLUSH, 8'h7F);

        // Zero clamps to one: a 1x1 grid; a cell past the frame acts as a flush
        write_reg(CFG_GRID_WIDTH, '0);
        write_reg(CFG_GRID_HEIGHT, '0);
        send_word(CMD_CELL, OCC_FREE);
        send_word(CMD_CELL, 8'h7F);
        while (ledger.advance != 0) send_word(CMD_FLUSH, OCC_FREE);

        // Indexes past the list are ignored
        write_reg(CFG_UNUSED_HI, '1);
        write_reg(CFG_UNUSED_LO, 11'd3);

        // 3x3 grid with a strong unknown next to a free cell, a stray flush mid-frame
        write_reg(CFG_GRID_WIDTH, 11'd3);
        write_reg(CFG_GRID_HEIGHT, 11'd3);
        foreach (grid3[i]) begin
            if (i == 4) send_word(CMD_FLUSH, 8'h55);
            send_word(CMD_CELL, grid3[i]);
        end
        while (ledger.advance != 0) send_word(CMD_FLUSH, 8'hAA);

        // Random frames, with the extreme sizes at fixed phases
        while (counted < RANDOM_ITEMS || phase < 14) begin
            steady = (phase >= 10 && phase < 14);
            tally  = 1'b1;
            case (phase)
                2: begin
                    // widest row: all-ones width clamps to the maximum
                    tally = 1'b0;
                    write_reg(CFG_GRID_WIDTH, '1);
                    write_reg(CFG_GRID_HEIGHT, 11'd1);
                end
                6: begin
                    // tallest column
                    tally = 1'b0;
                    write_reg(CFG_GRID_WIDTH, 11'd1);
                    write_reg(CFG_GRID_HEIGHT, '1);
                end
                10: begin
                    // two full-width rows, just past the maximum
                    tally = 1'b0;
                    write_reg(CFG_GRID_WIDTH, 11'd1025);
                    write_reg(CFG_GRID_HEIGHT, 11'd2);
                end
                default: begin
                    force_cfg = aborted || phase == 0 || phase == 3 ||
                                phase == 7 || phase == 11;
                    sel = $urandom_range(9);
                    if (sel == 0) begin
                        wr = 0;
                        hr = $urandom_range(8, 1);
                    end else if (sel < 3) begin
                        wr = $urandom_range(40, 9);
                        hr = $urandom_range(4, 1);
                    end else begin
                        wr = $urandom_range(8, 1);
                        hr = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
                    end
                    if (force_cfg || $urandom_range(9) < 6) begin
                        sel = force_cfg ? 2 : $urandom_range(2);
                        if (sel != 1) write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(wr));
                        if (sel != 0) write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(hr));
                    end
                    if ($urandom_range(7) == 0)
                        write_reg(CFG_INDEX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
                                  CFG_DATA_W'($urandom));
                end
            endcase
            run_frame(phase == 6, aborted);
            phase++;
        end
        steady = 1'b0;

        // Wait out the last reports
        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("Ran %0d frames over %0d cells, %0d early flushes dropped, %0d register writes",
                 ledger.frames_done, ledger.cells_taken, ledger.flushes_dropped, cfg_writes);
        $display("Checked %0d reports (%0d frontier cells), %0d mismatches, %0d left due",
                 ledger.reports_seen, ledger.frontier_hits, ledger.mismatches,
                 ledger.due_reports.size());
        if (ledger.mismatches == 0 && ledger.due_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fcd_pkg.sv
rtl/core/frontier_cell_detection.sv
tb/sv/frontier_cell_detection_tb.sv
